[hw/rtl/ipd_pkg.sv]
// shared types and constants for the ipd line message parser
// used by ipd_front, ipd_queue, ipd_back and ipd_line_message_parser_core
`timescale 1ns / 1ps

package ipd_pkg;

  localparam int unsigned DATA_PREFIX_LEN  = 8;
  localparam int unsigned ADMIN_PREFIX_LEN = 7;
  localparam int unsigned PAYLOAD_LEN      = 71;
  localparam int unsigned ADMIN_LEN        = 5;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_B       = 8'h42;
  localparam logic [7:0] ADMIN_BIAS   = 8'd65;
  localparam logic [7:0] MODE_KEEP    = 8'd42;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned TDATA_W = 56;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_RECORD  = 2'd1,
    KIND_ADMIN   = 2'd2
  } kind_e;

  // work handed from the front to the back for one received byte
  typedef struct packed {
    logic       has_pay;
    logic       end_rec;
    logic       end_adm;
    logic [6:0] pay_idx;
    logic [7:0] pay_byte;
    logic [6:0] recv;
    logic [7:0] adm1;
    logic [7:0] adm2;
    logic [7:0] adm3;
    logic [7:0] adm4;
  } entry_t;

  function automatic logic [7:0] data_tag(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h2C;
      3'd5:    c = 8'h37;
      3'd6:    c = 8'h32;
      default: c = 8'h3A;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] admin_tag(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h2C;
      3'd5:    c = 8'h36;
      default: c = 8'h3A;
    endcase
    return c;
  endfunction

  function automatic logic signed [8:0] minus65(input logic [7:0] b);
    return $signed({1'b0, b} - {1'b0, ADMIN_BIAS});
  endfunction

endpackage

[hw/rtl/ipd_line_message_parser_core.sv]
// top level of the ipd line message parser: front, queue and back
// depends on ipd_pkg, ipd_front, ipd_queue, ipd_back
`timescale 1ns / 1ps

// Splits received serial bytes into lines and reports payload bytes, data
// record completion and admin commands as result transfers. A byte can be
// taken every clock cycle while the queue is not full, and the back drives
// one result per cycle while the output is ready, so a line-ending payload
// byte (payload plus record complete) yields two result transfers. A
// two-entry queue between front and back lets bytes keep flowing while
// results wait; when the queue is full, the input pauses. Results pass
// through the queue and the back's output register.
// Results for one byte end with tlast set.
module ipd_line_message_parser_core import ipd_pkg::*; #(
  parameter int unsigned LINE_LIMIT = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // tdata: rx_byte
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,
  // tdata: payload_index[6:0], payload_byte[14:7], payload_received[21:15],
  // led_auto[30:22], mode_change[31], next_mode[40:32], power_off[41],
  // server_error[50:42], zero fill[55:51]
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  // tuser: kind[1:0]
  output logic [1:0]         m_axis_tuser_o,
  output logic               m_axis_tlast_o
);

  logic   q_full, q_push, q_pop, q_head_valid;
  entry_t q_push_data, q_head;

  ipd_front #(
    .LineLimit(LINE_LIMIT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_valid_i(s_axis_tvalid_i),
    .rx_byte_i (s_axis_tdata_i),
    .rx_ready_o(s_axis_tready_o),
    .q_full_i  (q_full),
    .push_o    (q_push),
    .entry_o   (q_push_data)
  );

  ipd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_valid_o(q_head_valid),
    .head_o      (q_head)
  );

  ipd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_head_valid),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

`ifndef NO_ASSERTIONS
  a_record_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_RECORD |-> m_axis_tlast_o)
    else $error("record complete not marked last");

  a_admin_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_ADMIN |-> m_axis_tlast_o)
    else $error("admin command not marked last");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head_valid)
    else $error("back popped an empty queue");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> q_head_valid)
    else $error("queue full and empty at once");
`endif

endmodule

[hw/rtl/ipd_front.sv]
// front end: tracks line position and prefixes, classifies each byte
// depends on ipd_pkg
`timescale 1ns / 1ps

module ipd_front import ipd_pkg::*; #(
  parameter int unsigned LineLimit = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       rx_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  localparam logic [7:0] LastPos = 8'(LineLimit - 1);

  logic [7:0] pos_q, pos_d;
  logic       data_ok_q, data_ok_d;
  logic       admin_ok_q, admin_ok_d;
  logic [7:0] adm_q [ADMIN_LEN];
  logic [7:0] adm_d [ADMIN_LEN];
  logic [6:0] cnt_q, cnt_d;

  logic       accept;
  logic       data_ok_n, admin_ok_n;
  logic [7:0] adm_n [ADMIN_LEN];
  logic       has_pay, line_end, end_rec, end_adm;
  logic [6:0] cnt_n;

  assign rx_ready_o = ~q_full_i;
  assign accept     = rx_valid_i & ~q_full_i;

  always_comb begin
    data_ok_n = data_ok_q;
    if (pos_q < 8'(DATA_PREFIX_LEN) && rx_byte_i != data_tag(pos_q[2:0])) begin
      data_ok_n = 1'b0;
    end
    admin_ok_n = admin_ok_q;
    if (pos_q < 8'(ADMIN_PREFIX_LEN) && rx_byte_i != admin_tag(pos_q[2:0])) begin
      admin_ok_n = 1'b0;
    end
    for (int i = 0; i < ADMIN_LEN; i++) begin
      adm_n[i] = (pos_q == 8'(ADMIN_PREFIX_LEN + i)) ? rx_byte_i : adm_q[i];
    end

    has_pay  = data_ok_n && pos_q >= 8'(DATA_PREFIX_LEN)
               && pos_q < 8'(DATA_PREFIX_LEN + PAYLOAD_LEN);
    cnt_n    = cnt_q + 7'(has_pay);
    line_end = (rx_byte_i == CHAR_NEWLINE) || (pos_q >= LastPos);
    end_rec  = line_end && data_ok_n && pos_q >= 8'(DATA_PREFIX_LEN);
    end_adm  = line_end && !end_rec && admin_ok_n && pos_q >= 8'(ADMIN_PREFIX_LEN)
               && adm_n[0] == CHAR_A;

    entry_o          = '0;
    entry_o.has_pay  = has_pay;
    entry_o.end_rec  = end_rec;
    entry_o.end_adm  = end_adm;
    entry_o.pay_idx  = has_pay ? 7'(pos_q - 8'(DATA_PREFIX_LEN)) : 7'd0;
    entry_o.pay_byte = has_pay ? rx_byte_i : 8'd0;
    entry_o.recv     = cnt_n;
    entry_o.adm1     = adm_n[1];
    entry_o.adm2     = adm_n[2];
    entry_o.adm3     = adm_n[3];
    entry_o.adm4     = adm_n[4];
    push_o           = accept && (has_pay || end_rec || end_adm);

    pos_d      = pos_q;
    data_ok_d  = data_ok_q;
    admin_ok_d = admin_ok_q;
    cnt_d      = cnt_q;
    for (int i = 0; i < ADMIN_LEN; i++) begin
      adm_d[i] = adm_q[i];
    end
    if (accept) begin
      if (line_end) begin
        pos_d      = '0;
        data_ok_d  = 1'b1;
        admin_ok_d = 1'b1;
        cnt_d      = '0;
        for (int i = 0; i < ADMIN_LEN; i++) begin
          adm_d[i] = '0;
        end
      end else begin
        pos_d      = pos_q + 8'd1;
        data_ok_d  = data_ok_n;
        admin_ok_d = admin_ok_n;
        cnt_d      = cnt_n;
        for (int i = 0; i < ADMIN_LEN; i++) begin
          adm_d[i] = adm_n[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      data_ok_q  <= 1'b1;
      admin_ok_q <= 1'b1;
      cnt_q      <= '0;
      for (int i = 0; i < ADMIN_LEN; i++) begin
        adm_q[i] <= '0;
      end
    end else begin
      pos_q      <= pos_d;
      data_ok_q  <= data_ok_d;
      admin_ok_q <= admin_ok_d;
      cnt_q      <= cnt_d;
      for (int i = 0; i < ADMIN_LEN; i++) begin
        adm_q[i] <= adm_d[i];
      end
    end
  end

endmodule

[hw/rtl/ipd_queue.sv]
// short queue of classified entries between front and back
// depends on ipd_pkg
`timescale 1ns / 1ps

module ipd_queue import ipd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   head_valid_o,
  output entry_t head_o
);

  entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/ipd_back.sv]
// back end: expands queued entries into result transfers, output register
// depends on ipd_pkg
`timescale 1ns / 1ps

module ipd_back import ipd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  entry_t             head_i,
  output logic               pop_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [TDATA_W-1:0] m_tdata_o,
  output logic [1:0]         m_tuser_o,
  output logic               m_tlast_o
);

  logic              valid_q, valid_d;
  logic              phase_q, phase_d;
  kind_e             kind_q, kind_d;
  logic [6:0]        idx_q, idx_d;
  logic [7:0]        byte_q, byte_d;
  logic [6:0]        recv_q, recv_d;
  logic signed [8:0] led_q, led_d;
  logic              mc_q, mc_d;
  logic signed [8:0] nm_q, nm_d;
  logic              po_q, po_d;
  logic signed [8:0] se_q, se_d;
  logic              last_q, last_d;
  logic              load;

  assign load = ~valid_q | m_tready_i;

  always_comb begin
    pop_o   = 1'b0;
    phase_d = phase_q;
    valid_d = valid_q;
    kind_d  = KIND_PAYLOAD;
    idx_d   = '0;
    byte_d  = '0;
    recv_d  = '0;
    led_d   = '0;
    mc_d    = 1'b0;
    nm_d    = '0;
    po_d    = 1'b0;
    se_d    = '0;
    last_d  = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        if (!phase_q && head_i.has_pay) begin
          kind_d = KIND_PAYLOAD;
          idx_d  = head_i.pay_idx;
          byte_d = head_i.pay_byte;
          if (head_i.end_rec || head_i.end_adm) begin
            phase_d = 1'b1;
          end else begin
            last_d = 1'b1;
            pop_o  = 1'b1;
          end
        end else begin
          phase_d = 1'b0;
          pop_o   = 1'b1;
          last_d  = 1'b1;
          if (head_i.end_rec) begin
            kind_d = KIND_RECORD;
            recv_d = head_i.recv;
          end else begin
            kind_d = KIND_ADMIN;
            led_d  = minus65(head_i.adm1);
            mc_d   = (head_i.adm2 != ADMIN_BIAS + MODE_KEEP);
            nm_d   = minus65(head_i.adm2);
            po_d   = (head_i.adm3 == CHAR_B);
            se_d   = minus65(head_i.adm4);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      idx_q  <= idx_d;
      byte_q <= byte_d;
      recv_q <= recv_d;
      led_q  <= led_d;
      mc_q   <= mc_d;
      nm_q   <= nm_d;
      po_q   <= po_d;
      se_q   <= se_d;
      last_q <= last_d;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tuser_o  = kind_q;
  assign m_tlast_o  = last_q;
  assign m_tdata_o  = {5'd0, se_q, po_q, nm_q, mc_q, led_q, recv_q, byte_q, idx_q};

endmodule
